/* src/line_edit_buffer_unit_assert.svh */
// Assertion macros for the line edit buffer.
// Each macro takes a label, a clock, a reset (active low), an antecedent and a consequent.
`ifndef LINE_EDIT_BUFFER_UNIT_ASSERT_SVH
`define LINE_EDIT_BUFFER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LEB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line edit buffer: same-cycle check failed");

// Next-cycle implication.
`define LEB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line edit buffer: next-cycle check failed");

`else

`define LEB_ASSERT_SAME(label, clk, rstn, ante, cons)
`define LEB_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* src/leb_pkg.sv */
package leb_pkg;

    localparam int unsigned DEPTH_DEF = 128;

    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_BACKSPACE = 4'd1,
        OP_DELETE    = 4'd2,
        OP_LEFT      = 4'd3,
        OP_RIGHT     = 4'd4,
        OP_HOME      = 4'd5,
        OP_END       = 4'd6,
        OP_CLEAR     = 4'd7,
        OP_READ      = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] char_in;
        logic [6:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] char_out;
        logic [6:0] line_length;
        logic [6:0] cursor_pos;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic item_load;
        logic ptr_load;
        logic shift_step;
        logic rd_issue;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_shift;
        logic is_read;
        logic more;
        logic res_free;
    } status_t;

endpackage

/* src/leb_ctrl.sv */
module leb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  leb_pkg::status_t status,
    output leb_pkg::cmd_t    cmd
);
    import leb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (status.is_shift) begin
                    cmd.ptr_load = 1'b1;
                    state_next   = ST_SHIFT;
                end else if (status.is_read) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_DRAIN;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SHIFT: begin
                if (status.more) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last moved byte landed at the previous edge; go on to commit
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.res_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/leb_datapath.sv */
module leb_datapath #(
    parameter int unsigned DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  leb_pkg::in_word_t  s_data,
    input  leb_pkg::cmd_t      cmd,
    output leb_pkg::status_t   status,
    output logic               m_valid,
    input  logic               m_ready,
    output leb_pkg::out_word_t m_data
);
    import leb_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = (AW > 7) ? AW : 7;

    logic [7:0]    line_mem [DEPTH];
    logic [7:0]    rd_data_reg;

    in_word_t      item_reg;
    logic [AW-1:0] length_reg, length_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          pend_reg;
    logic [AW-1:0] mv_addr_reg;
    logic          m_valid_reg;
    out_word_t     result_reg;

    logic          op_ok;
    logic          is_ins;
    logic          is_bksp;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    assign is_ins  = (item_reg.op == OP_INSERT);
    assign is_bksp = (item_reg.op == OP_BACKSPACE);

    // Decide whether the held op takes effect.
    always_comb begin
        op_ok = 1'b0;
        unique case (item_reg.op)
            OP_INSERT:    op_ok = ((AW+1)'({1'b0, length_reg}) + (AW+1)'(1)) < (AW+1)'(DEPTH);
            OP_BACKSPACE: op_ok = (cursor_reg != '0);
            OP_DELETE:    op_ok = (cursor_reg < length_reg);
            OP_LEFT:      op_ok = (cursor_reg != '0);
            OP_RIGHT:     op_ok = (cursor_reg < length_reg);
            OP_HOME,
            OP_END,
            OP_CLEAR:     op_ok = 1'b1;
            OP_READ:      op_ok = CW'(item_reg.read_index) < CW'(length_reg);
            default:      op_ok = 1'b0;
        endcase
    end

    always_comb begin
        status.is_shift = op_ok && (is_ins || is_bksp || item_reg.op == OP_DELETE);
        status.is_read  = op_ok && (item_reg.op == OP_READ);
        if (is_ins) begin
            status.more = (ptr_reg > cursor_reg);
        end else begin
            status.more = ((AW+1)'({1'b0, ptr_reg}) + (AW+1)'(1)) < (AW+1)'({1'b0, length_reg});
        end
        status.res_free = !m_valid_reg || m_ready;
    end

    // Pointer walk: insert walks down from the end, removals walk up.
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_load) begin
            priority if (is_ins) begin
                ptr_next = length_reg;
            end else if (is_bksp) begin
                ptr_next = cursor_reg - AW'(1);
            end else begin
                ptr_next = cursor_reg;
            end
        end else if (cmd.shift_step) begin
            ptr_next = is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        end
    end

    // Memory port selection
    always_comb begin
        mem_re = cmd.shift_step || cmd.rd_issue;
        if (cmd.shift_step) begin
            mem_ra = is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        end else begin
            mem_ra = AW'(item_reg.read_index);
        end
        if (pend_reg) begin
            mem_we = 1'b1;
            mem_wa = mv_addr_reg;
            mem_wd = rd_data_reg;
        end else begin
            mem_we = cmd.commit && op_ok && is_ins;
            mem_wa = cursor_reg;
            mem_wd = item_reg.char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= line_mem[mem_ra];
        end
    end

    // Length and cursor after the held op
    always_comb begin
        length_next = length_reg;
        cursor_next = cursor_reg;
        if (op_ok) begin
            unique case (item_reg.op)
                OP_INSERT: begin
                    length_next = length_reg + AW'(1);
                    cursor_next = cursor_reg + AW'(1);
                end
                OP_BACKSPACE: begin
                    length_next = length_reg - AW'(1);
                    cursor_next = cursor_reg - AW'(1);
                end
                OP_DELETE: length_next = length_reg - AW'(1);
                OP_LEFT:   cursor_next = cursor_reg - AW'(1);
                OP_RIGHT:  cursor_next = cursor_reg + AW'(1);
                OP_HOME:   cursor_next = '0;
                OP_END:    cursor_next = length_reg;
                OP_CLEAR: begin
                    length_next = '0;
                    cursor_next = '0;
                end
                default: begin
                    length_next = length_reg;
                    cursor_next = cursor_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            cursor_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.shift_step;
            if (cmd.commit) begin
                length_reg  <= length_next;
                cursor_reg  <= cursor_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        ptr_reg <= ptr_next;
        if (cmd.shift_step) begin
            mv_addr_reg <= ptr_reg;
        end
        if (cmd.commit) begin
            result_reg.ok          <= op_ok;
            result_reg.char_out    <= (op_ok && item_reg.op == OP_READ) ? rd_data_reg : 8'd0;
            result_reg.line_length <= 7'(length_next);
            result_reg.cursor_pos  <= 7'(cursor_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = result_reg;

endmodule

/* src/line_edit_buffer_unit.sv */
// Channel   Dir  Word         Handshake
// s_        in   in_word_t    s_valid / s_ready   edit command: op, char_in, read_index
// m_        out  out_word_t   m_valid / m_ready   result: ok, char_out, line_length, cursor_pos
//
// One word at a time. Cursor moves, home, end, clear and refused edits go from decode to commit;
// read issues its memory read in decode and goes through drain to commit. Insert and
// removals move the tail through the line memory (one read and one write port) one byte per
// cycle in the shift state, then drain the last move and commit. The next word is taken from
// the cycle the result first shows. Reset (aresetn, synchronous, active low) empties the line;
// the memory is not cleared. A stalled result holds in the output register while the next
// word is taken; its commit waits only if the register is still full.
`include "line_edit_buffer_unit_assert.svh"

module line_edit_buffer_unit #(
    parameter int unsigned DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  leb_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output leb_pkg::out_word_t m_data
);
    import leb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each word: decode, walk the tail for shifting edits, drain the last move or read, commit.
    leb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the line memory, length, cursor and the result register.
    leb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A word just taken keeps the input closed until its result commits.
    `LEB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Commit only into a free result register.
    `LEB_ASSERT_SAME(a_commit_free, aclk, aresetn, cmd.commit, status.res_free)
    // Every commit shows a result on the next cycle.
    `LEB_ASSERT_NEXT(a_commit_shows, aclk, aresetn, cmd.commit, m_valid)
    // Move a byte only while the walk still has work.
    `LEB_ASSERT_SAME(a_step_needed, aclk, aresetn, cmd.shift_step, status.more && !s_ready)

endmodule
